[src/fawsk_pkg.sv]
// shared types and constants for the flow accumulation block
`default_nettype none
package fawsk_pkg;
	localparam int QW = 48;
	localparam int MAX_CELLS = 65536;
	localparam logic [QW-1:0] Q_MAX = {QW{1'b1}};
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PROC = 1'b1;
	localparam logic [0:0] REG_RUNOFF = 1'b0;
	localparam logic [0:0] REG_AREA = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] cell_index;
		logic        flood_flag;
		logic [15:0] steepest_neighbor;
		logic [47:0] initial_discharge;
		logic [16:0] flooded_cells;
		logic [47:0] storage_volume;
		logic [16:0] ratio_first;
		logic [16:0] ratio_second;
		logic [15:0] first_neighbor;
		logic [15:0] second_neighbor;
	} item_t;

	typedef struct packed {
		logic [15:0] out_cell;
		logic [47:0] upstream_discharge;
		logic [47:0] inflow;
		logic [47:0] lake_inflow;
		logic        overflowing;
	} result_t;

	function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [QW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[QW] ? Q_MAX : s[QW-1:0];
	endfunction
endpackage
`default_nettype wire

[src/fawsk_queue.sv]
// short item queue between the front and the back
`default_nettype none
module fawsk_queue
	import fawsk_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  wire   out_ready,
	output item_t out_item
);
	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

[src/fawsk_back.sv]
// sequencer that runs one item through the cell maps and accumulators
`default_nettype none
module fawsk_back
	import fawsk_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire  [23:0]  annual_runoff,
	input  wire  [20:0]  grid_area,
	input  wire          in_valid,
	output logic         in_ready,
	input  item_t        in_item,
	output logic         res_valid,
	input  wire          res_ready,
	output result_t      res
);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int IW = (AW < 16) ? AW : 16;

	localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_RD = 4'd2, S_W1 = 4'd3,
		S_M1 = 4'd4, S_M2 = 4'd5, S_T1 = 4'd6, S_T2 = 4'd7, S_RT = 4'd8,
		S_A1 = 4'd9, S_A2 = 4'd10, S_OUT = 4'd11, S_LK = 4'd12, S_LK2 = 4'd13;

	// maps and accumulators, one port each
	logic [AW-1:0] st_map [MAX_CELLS];
	logic          fl_map [MAX_CELLS];
	logic [QW-1:0] inf_mem [MAX_CELLS];
	logic [QW-1:0] lak_mem [MAX_CELLS];

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	item_t         it_q;
	logic [AW-1:0] c_q;
	logic [QW-1:0] inf_rd_q, lak_rd_q, total_q, recv_q, lake_q, amt_q;
	logic          ov_q, fl_rd_q, which_q;
	logic [AW-1:0] st_rd_q, tgt_q;
	logic [61:0]   run_q;
	logic [44:0]   ra_q;
	logic [64:0]   sh_q;
	logic          res_valid_q;
	result_t       res_q;
	logic          res_free;

	// address and enables computed combinationally from the sequencer
	logic [AW-1:0] map_a, inf_a, lak_a;
	logic          map_we, inf_we, lak_we;
	logic [QW-1:0] inf_wd, lak_wd;

	function automatic logic [AW-1:0] cell_of(input logic [15:0] v);
		logic [AW-1:0] r;
		r = '0;
		r[IW-1:0] = v[IW-1:0];
		return r;
	endfunction

	function automatic logic [QW-1:0] sat64(input logic [64:0] v);
		return (|v[64:QW]) ? Q_MAX : v[QW-1:0];
	endfunction

	// the result register frees when empty or taken this cycle
	assign res_free  = !res_valid_q || res_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		map_a = c_q; inf_a = c_q; lak_a = c_q;
		map_we = 1'b0; inf_we = 1'b0; lak_we = 1'b0;
		inf_wd = '0; lak_wd = '0;
		unique case (state_q)
			S_CLR: begin
				inf_a = clr_q; lak_a = clr_q;
				inf_we = 1'b1; lak_we = 1'b1;
			end
			S_W1: map_we = (it_q.command == CMD_LOAD);
			S_LK: begin
				lak_we = 1'b1; lak_wd = lake_q;
			end
			S_LK2: begin
				inf_we = 1'b1; inf_wd = recv_q;
			end
			S_RT: map_a = tgt_q;
			S_A1: begin
				// keep the target's map entry on the read port for the update
				map_a = tgt_q;
				inf_a = tgt_q; lak_a = st_rd_q;
			end
			S_A2: begin
				inf_a = tgt_q; lak_a = st_rd_q;
				if (fl_rd_q) begin
					lak_we = 1'b1; lak_wd = sat_add(lak_rd_q, amt_q);
				end else begin
					inf_we = 1'b1; inf_wd = sat_add(inf_rd_q, amt_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			st_map[map_a] <= cell_of(it_q.steepest_neighbor);
			fl_map[map_a] <= it_q.flood_flag;
		end
		st_rd_q <= st_map[map_a];
		fl_rd_q <= fl_map[map_a];
		if (inf_we) inf_mem[inf_a] <= inf_wd;
		inf_rd_q <= inf_mem[inf_a];
		if (lak_we) lak_mem[lak_a] <= lak_wd;
		lak_rd_q <= lak_mem[lak_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && res_free) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_CELLS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid && in_ready) state_q <= S_RD;
				S_RD: state_q <= S_W1;
				S_W1: state_q <= (it_q.command == CMD_LOAD) ? S_OUT : S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= (it_q.flooded_cells == 17'd0) ? S_T1 : S_LK;
				S_LK: state_q <= S_LK2;
				S_LK2: state_q <= S_RT;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_RT;
				S_RT: state_q <= S_A1;
				S_A1: state_q <= S_A2;
				S_A2: begin
					if (it_q.flooded_cells == 17'd0 && !which_q) state_q <= S_RT;
					else state_q <= S_OUT;
				end
				S_OUT: if (res_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, one multiply per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				it_q <= in_item;
				c_q <= cell_of(in_item.cell_index);
				which_q <= 1'b0;
				ov_q <= 1'b0;
			end
			S_W1: begin
				// memories hold this cell's accumulators and map entry now
				recv_q <= inf_rd_q;
				lake_q <= lak_rd_q;
				ra_q <= 45'(annual_runoff) * 45'(grid_area);
			end
			S_M1: run_q <= 62'(ra_q) * 62'(it_q.flooded_cells);
			S_M2: begin
				if (it_q.flooded_cells != 17'd0) begin
					lake_q <= sat_add(lake_q, (|run_q[61:QW]) ? Q_MAX : run_q[QW-1:0]);
				end else begin
					total_q <= sat_add(it_q.initial_discharge, recv_q);
				end
			end
			S_T1: begin
				sh_q <= 65'(total_q) * 65'(it_q.ratio_first);
				tgt_q <= cell_of(it_q.first_neighbor);
				lake_q <= lak_rd_q;
			end
			S_T2: begin
				sh_q <= 65'(total_q) * 65'(it_q.ratio_second);
				amt_q <= sat64(sh_q >> 16);
			end
			S_LK: begin
				if (lake_q > it_q.storage_volume) begin
					recv_q <= sat_add(recv_q, lake_q - it_q.storage_volume);
					ov_q <= 1'b1;
				end
			end
			S_LK2: begin
				total_q <= sat_add(it_q.initial_discharge, recv_q);
				amt_q <= sat_add(it_q.initial_discharge, recv_q);
				tgt_q <= st_rd_q;
			end
			S_A2: begin
				if (it_q.flooded_cells == 17'd0 && !which_q) begin
					which_q <= 1'b1;
					amt_q <= sat64(sh_q >> 16);
					tgt_q <= cell_of(it_q.second_neighbor);
				end
				// track own lake entry if this update touched it
				if (fl_rd_q && st_rd_q == c_q) lake_q <= sat_add(lak_rd_q, amt_q);
			end
			S_OUT: begin
				if (res_free) begin
					res_q.out_cell <= it_q.cell_index;
					if (it_q.command == CMD_LOAD) begin
						res_q.upstream_discharge <= '0;
						res_q.inflow <= '0;
						res_q.lake_inflow <= '0;
						res_q.overflowing <= 1'b0;
					end else begin
						res_q.upstream_discharge <= total_q;
						res_q.inflow <= recv_q;
						res_q.lake_inflow <= lake_q;
						res_q.overflowing <= ov_q;
					end
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[src/flow_accumulation_with_sinks.sv]
// top level of the flow accumulation block with lake sinks
//
// s_axis carries one command item per transfer; tuser selects loading a cell
// map entry (0) or processing one cell (1). m_axis returns one result item
// per command, in order. cfg writes annual_runoff (index 0) and the area of
// one grid cell (index 1); write it only while no item is in flight.
// A two-entry queue takes items; the back sequencer runs each one against
// single-port cell memories, one state per cycle unless S_OUT waits for a
// free result register. A load only writes the cell map entry; a lake outlet
// and an ordinary cell run the read-modify-write sequence for the own cell and
// one routed target (two for an ordinary cell). The back takes a new item
// only once it has finished the last one and registered its result.
// After reset both accumulator memories are swept to zero, one entry per
// cycle over all 65536 entries; the queue still takes two items meanwhile.
// A stalled m_axis holds its result; the back finishes the next item and
// waits with it, and the queue keeps taking items until full.
`default_nettype none
module flow_accumulation_with_sinks
	import fawsk_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// command
	input  wire  [0:0]   s_axis_tuser,
	// cell_index, flood_flag, steepest_neighbor, initial_discharge,
	// flooded_cells, storage_volume, ratio_first, ratio_second,
	// first_neighbor, second_neighbor, zero pad (216 bits)
	input  wire  [215:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// out_cell, upstream_discharge, inflow, lake_inflow, overflowing, pad
	output logic [167:0] m_axis_tdata,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [0:0]   cfg_index,
	input  wire  [23:0]  cfg_data
);
	logic [23:0] runoff_q;
	logic [20:0] area_q;
	item_t   fi, qi;
	logic    q_valid, q_ready;
	result_t r;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runoff_q <= '0;
			area_q <= 21'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RUNOFF: runoff_q <= cfg_data;
				REG_AREA: area_q <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	assign fi.command           = s_axis_tuser[0];
	assign fi.cell_index        = s_axis_tdata[15:0];
	assign fi.flood_flag        = s_axis_tdata[16];
	assign fi.steepest_neighbor = s_axis_tdata[32:17];
	assign fi.initial_discharge = s_axis_tdata[80:33];
	assign fi.flooded_cells     = s_axis_tdata[97:81];
	assign fi.storage_volume    = s_axis_tdata[145:98];
	assign fi.ratio_first       = s_axis_tdata[162:146];
	assign fi.ratio_second      = s_axis_tdata[179:163];
	assign fi.first_neighbor    = s_axis_tdata[195:180];
	assign fi.second_neighbor   = s_axis_tdata[211:196];

	fawsk_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(fi),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(qi)
	);

	fawsk_back u_back (
		.clk(clk), .arst_n(arst_n),
		.annual_runoff(runoff_q), .grid_area(area_q),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(qi),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tdata = {7'd0, r.overflowing, r.lake_inflow, r.inflow,
		r.upstream_discharge, r.out_cell};
endmodule
`default_nettype wire
